// ===== hdl/lpcmpk_pkg.sv =====
// LPCM packetizer package: types, constants and table functions.
// Used by every module of the packetizer and by its checker.
`timescale 1ns / 1ps
`default_nettype none
package lpcmpk_pkg;

	localparam int unsigned PAYLOAD_LIMIT_DEF = 2016;
	localparam int unsigned HDR_BYTES         = 14;
	localparam int unsigned GROUP_MAX         = 12;
	localparam int unsigned GROUP_NARROW      = 2;
	localparam int unsigned MAX_SUB           = 3840;
	localparam int unsigned MIN_SUB           = 80;
	localparam int unsigned QUEUE_DEPTH       = 2;
	localparam int unsigned CFG_DATA_W        = 4;
	localparam int unsigned CFG_IDX_W         = 2;
	localparam int unsigned STEP_W            = $clog2(HDR_BYTES + GROUP_MAX);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RATE  = 2'd0,
		REG_CHANS = 2'd1,
		REG_WIDE  = 2'd2
	} cfg_reg_t;

	localparam logic [2:0] RATE_RST  = 3'd0;
	localparam logic [3:0] CHANS_RST = 4'd2;
	localparam logic       WIDE_RST  = 1'b0;

	localparam logic [7:0] HDR_SYNC   = 8'hA0;
	localparam logic [7:0] HDR_LOW    = 8'h0F;
	localparam logic [7:0] HDR_WIDE   = 8'h20;
	localparam logic [7:0] HDR_MARK   = 8'h80;
	localparam logic [7:0] HDR_PTR_LO = 8'h0A;
	localparam logic [7:0] HDR_PTR_HI = 8'h09;

	typedef struct packed {
		logic [2:0] rate;
		logic [3:0] chans;
		logic       wide;
	} cfg_t;

	typedef enum logic [1:0] {
		SHP_IDLE,
		SHP_MUL,
		SHP_DIV
	} shp_state_t;

	typedef struct packed {
		logic [GROUP_MAX-1:0][7:0] grp;
		logic                      hdr;
		logic [4:0]                fc;
		logic                      pend;
	} job_t;

	function automatic logic [3:0] eff_chans(input logic [3:0] c);
		logic [3:0] r;
		r = c;
		if (c == 4'd0)
			r = 4'd1;
		else if (c > 4'd8)
			r = 4'd8;
		return r;
	endfunction

	function automatic logic [7:0] rate_bits(input logic [2:0] r);
		logic [7:0] b;
		case (r)
			3'd1: b = 8'h10;
			3'd2: b = 8'h20;
			3'd3: b = 8'h80;
			3'd4: b = 8'h90;
			3'd5: b = 8'hA0;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] rate_base(input logic [2:0] r);
		logic [7:0] b;
		case (r)
			3'd1, 3'd4: b = 8'd80;
			3'd2, 3'd5: b = 8'd160;
			default: b = 8'd40;
		endcase
		return b;
	endfunction

	// source slot in the group for output position p
	function automatic logic [3:0] payload_src(input logic wide, input logic [3:0] p);
		logic [3:0] s;
		if (!wide) begin
			s = {3'd0, ~p[0]};
		end else begin
			case (p)
				4'd0:  s = 4'd2;
				4'd1:  s = 4'd1;
				4'd2:  s = 4'd5;
				4'd3:  s = 4'd4;
				4'd4:  s = 4'd8;
				4'd5:  s = 4'd7;
				4'd6:  s = 4'd6;
				4'd7:  s = 4'd11;
				4'd8:  s = 4'd0;
				4'd9:  s = 4'd3;
				4'd10: s = 4'd10;
				4'd11: s = 4'd9;
				default: s = 4'd0;
			endcase
		end
		return s;
	endfunction

	function automatic logic [7:0] hdr_byte(input logic [3:0] i, input logic [4:0] fc,
		input cfg_t cfg);
		logic [7:0] b;
		case (i)
			4'd0:  b = HDR_SYNC;
			4'd1:  b = {3'd0, fc};
			4'd3:  b = HDR_PTR_LO;
			4'd5:  b = HDR_PTR_HI;
			4'd7:  b = cfg.wide ? (HDR_LOW | HDR_WIDE) : HDR_LOW;
			4'd8:  b = HDR_LOW | rate_bits(cfg.rate);
			4'd10: b = {4'd0, eff_chans(cfg.chans) - 4'd1};
			4'd11: b = HDR_MARK;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

// ===== hdl/lpcmpk_cfg.sv =====
// Configuration registers and packet shape unit (payload length, subframes).
// Depends on lpcmpk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lpcmpk_cfg #(
	parameter int unsigned PAYLOAD_LIMIT = lpcmpk_pkg::PAYLOAD_LIMIT_DEF,
	parameter int unsigned LEN_W         = 13,
	parameter int unsigned SUBS_W        = 6
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   cfg_valid,
	output logic                                  cfg_ready,
	input  wire  [lpcmpk_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire  [lpcmpk_pkg::CFG_DATA_W-1:0]     cfg_data,
	output lpcmpk_pkg::cfg_t                      cfg,
	output logic [LEN_W-1:0]                      len,
	output logic [SUBS_W-1:0]                     subs,
	output logic                                  busy,
	output logic                                  restart
);
	import lpcmpk_pkg::*;

	localparam int unsigned LIM_W = $clog2(PAYLOAD_LIMIT + 1);
	localparam int unsigned SUB_W = $clog2(MAX_SUB + 1);
	localparam int unsigned CMP_W = LIM_W > SUB_W ? LIM_W : SUB_W;

	cfg_t             cfg_q;
	shp_state_t       state_q, state_d;
	logic [SUB_W-1:0] sub_q;
	logic [LIM_W-1:0] rem_q;
	logic [LEN_W-1:0] len_q;
	logic [SUBS_W-1:0] n_q;
	logic [10:0]      base_ch;
	logic [SUB_W-1:0] sub_d;
	logic             fits;

	assign cfg_ready = 1'b1;
	assign restart   = cfg_valid && (cfg_index == REG_RATE || cfg_index == REG_CHANS ||
		cfg_index == REG_WIDE);
	assign cfg  = cfg_q;
	assign len  = len_q;
	assign subs = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate  <= RATE_RST;
			cfg_q.chans <= CHANS_RST;
			cfg_q.wide  <= WIDE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_RATE:  cfg_q.rate  <= cfg_data[2:0];
				REG_CHANS: cfg_q.chans <= cfg_data;
				REG_WIDE:  cfg_q.wide  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign base_ch = 11'(rate_base(cfg_q.rate)) * 11'(eff_chans(cfg_q.chans));
	assign sub_d   = cfg_q.wide ? SUB_W'(base_ch) + SUB_W'({base_ch, 1'b0})
		: SUB_W'({base_ch, 1'b0});
	assign fits    = CMP_W'(rem_q) >= CMP_W'(sub_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			SHP_MUL:  state_d = SHP_DIV;
			SHP_DIV:  if (!fits) state_d = SHP_IDLE;
			SHP_IDLE: state_d = SHP_IDLE;
			default:  state_d = SHP_IDLE;
		endcase
		if (restart)
			state_d = SHP_MUL;
	end

	always_comb begin
		case (state_q)
			SHP_IDLE: busy = 1'b0;
			default:  busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= SHP_MUL;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			SHP_MUL: begin
				sub_q <= sub_d;
				rem_q <= LIM_W'(PAYLOAD_LIMIT);
				n_q   <= '0;
				len_q <= '0;
			end
			SHP_DIV: begin
				if (fits) begin
					rem_q <= rem_q - LIM_W'(sub_q);
					n_q   <= n_q + SUBS_W'(1);
					len_q <= len_q + LEN_W'(sub_q);
				end else if (n_q == '0) begin
					n_q   <= SUBS_W'(1);
					len_q <= LEN_W'(sub_q);
				end
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== hdl/lpcmpk_front.sv =====
// Front end: accepts PCM bytes, gathers sample groups, decides header and packet end.
// Depends on lpcmpk_pkg; pushes one job per complete group into lpcmpk_queue.
`timescale 1ns / 1ps
`default_nettype none
module lpcmpk_front #(
	parameter int unsigned LEN_W  = 13,
	parameter int unsigned SUBS_W = 6,
	parameter int unsigned CNT_W  = 13
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     s_tvalid,
	output logic                    s_tready,
	input  wire  [7:0]              s_tdata,
	input  lpcmpk_pkg::cfg_t        cfg,
	input  wire  [LEN_W-1:0]        len,
	input  wire  [SUBS_W-1:0]       subs,
	input  wire                     shape_busy,
	input  wire                     restart,
	input  wire                     q_full,
	output logic                    push,
	output lpcmpk_pkg::job_t        push_job
);
	import lpcmpk_pkg::*;

	localparam int unsigned EXT_W = SUBS_W > 5 ? SUBS_W : 5;

	logic [GROUP_MAX-1:0][7:0] group_q, group_d;
	logic [3:0]       fill_q;
	logic [CNT_W-1:0] cnt_q, cnt_sum;
	logic [4:0]       frame_q, frame_d;
	logic             hdr_due_q;
	logic [3:0]       gsize;
	logic             accept, complete, pend;
	logic [EXT_W-1:0] subs_ext;

	assign s_tready = !shape_busy && !q_full;
	assign accept   = s_tvalid && s_tready;
	assign gsize    = cfg.wide ? 4'(GROUP_MAX) : 4'(GROUP_NARROW);
	assign complete = (fill_q + 4'd1) >= gsize;
	assign cnt_sum  = cnt_q + CNT_W'(gsize);
	assign pend     = cnt_sum >= CNT_W'(len);
	assign subs_ext = EXT_W'(subs);
	assign frame_d  = hdr_due_q ? frame_q + subs_ext[4:0] : frame_q;

	always_comb begin
		for (int j = 0; j < GROUP_MAX; j++)
			group_d[j] = (fill_q == 4'(j)) ? s_tdata : group_q[j];
	end

	assign push          = accept && complete;
	assign push_job.grp  = group_d;
	assign push_job.hdr  = hdr_due_q;
	assign push_job.fc   = frame_d;
	assign push_job.pend = pend;

	always_ff @(posedge clk) begin
		if (accept)
			group_q <= group_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q    <= '0;
			cnt_q     <= '0;
			frame_q   <= '0;
			hdr_due_q <= 1'b1;
		end else if (restart) begin
			fill_q    <= '0;
			cnt_q     <= '0;
			frame_q   <= '0;
			hdr_due_q <= 1'b1;
		end else if (accept) begin
			if (complete) begin
				fill_q    <= '0;
				frame_q   <= frame_d;
				hdr_due_q <= pend;
				cnt_q     <= pend ? '0 : cnt_sum;
			end else begin
				fill_q <= fill_q + 4'd1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/lpcmpk_queue.sv =====
// Short job queue between front and back end.
// Depends on lpcmpk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lpcmpk_queue (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  lpcmpk_pkg::job_t    push_job,
	output logic                full,
	input  wire                 pop,
	output lpcmpk_pkg::job_t    pop_job,
	output logic                not_empty
);
	import lpcmpk_pkg::*;

	localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full      = cnt_q == CNT_W'(QUEUE_DEPTH);
	assign not_empty = cnt_q != '0;
	assign pop_job   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			if (pop)
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + CNT_W'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - CNT_W'(1);
		end
	end

endmodule
`default_nettype wire

// ===== hdl/lpcmpk_back.sv =====
// Back end: walks one job per group, emitting header and reordered payload bytes.
// Depends on lpcmpk_pkg; drives the output register of the packet stream.
`timescale 1ns / 1ps
`default_nettype none
module lpcmpk_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  lpcmpk_pkg::cfg_t    cfg,
	input  wire                 q_not_empty,
	input  lpcmpk_pkg::job_t    q_job,
	output logic                pop,
	output logic                m_tvalid,
	input  wire                 m_tready,
	output logic [7:0]          m_tdata,
	output logic [1:0]          m_tuser,
	output logic                m_tlast
);
	import lpcmpk_pkg::*;

	job_t              job_q;
	logic              busy_q;
	logic [STEP_W-1:0] step_q, last_step, pay_step;
	logic              adv, emit, is_last, in_hdr;
	logic [7:0]        byte_d;
	logic              m_tvalid_q, m_tlast_q;
	logic [7:0]        m_tdata_q;
	logic [1:0]        m_tuser_q;

	assign adv       = !m_tvalid_q || m_tready;
	assign emit      = busy_q && adv;
	assign last_step = cfg.wide ? STEP_W'(HDR_BYTES + GROUP_MAX - 1)
		: STEP_W'(HDR_BYTES + GROUP_NARROW - 1);
	assign is_last   = step_q == last_step;
	assign in_hdr    = step_q < STEP_W'(HDR_BYTES);
	assign pay_step  = step_q - STEP_W'(HDR_BYTES);
	assign pop       = q_not_empty && (!busy_q || (emit && is_last));
	assign byte_d    = in_hdr ? hdr_byte(step_q[3:0], job_q.fc, cfg)
		: job_q.grp[payload_src(cfg.wide, pay_step[3:0])];

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	always_ff @(posedge clk) begin
		if (pop)
			job_q <= q_job;
		if (emit) begin
			m_tdata_q <= byte_d;
			m_tuser_q <= {job_q.pend && is_last, in_hdr};
			m_tlast_q <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			step_q     <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				step_q <= q_job.hdr ? '0 : STEP_W'(HDR_BYTES);
			end else if (emit) begin
				step_q <= step_q + STEP_W'(1);
				if (is_last)
					busy_q <= 1'b0;
			end
			if (emit)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

// ===== hdl/lpcm_audio_packetizer_unit.sv =====
// Top level of the DVD LPCM packetizer: config/shape unit, front end, job queue, back end.
// Depends on lpcmpk_pkg, lpcmpk_cfg, lpcmpk_front, lpcmpk_queue, lpcmpk_back.
//
// Channel   Signals                                       Direction
// input     s_tvalid s_tready s_tdata                     in  (PCM bytes)
// output    m_tvalid m_tready m_tdata m_tuser m_tlast     out (packet bytes)
// config    cfg_valid cfg_ready cfg_index cfg_data        in  (register writes)
//
// One input byte per cycle while the shape unit is idle and the job queue has room;
// one output byte per cycle while jobs wait and m_tready is high. Output stalls back up
// through the queue to s_tready. A complete group produces 2 or 12 payload bytes, plus
// 14 header bytes at packet start. After reset or a rate, channel or width write,
// s_tready is low while the shape unit divides PAYLOAD_LIMIT by the subframe size.
`timescale 1ns / 1ps
`default_nettype none
module lpcm_audio_packetizer_unit #(
	parameter int unsigned PAYLOAD_LIMIT = lpcmpk_pkg::PAYLOAD_LIMIT_DEF
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               s_tvalid,
	output logic                              s_tready,
	input  wire  [7:0]                        s_tdata,   // [7:0] sample_byte
	output logic                              m_tvalid,
	input  wire                               m_tready,
	output logic [7:0]                        m_tdata,   // [7:0] out_byte
	output logic [1:0]                        m_tuser,   // [0] in_header, [1] packet_end
	output logic                              m_tlast,   // run_last
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire  [lpcmpk_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire  [lpcmpk_pkg::CFG_DATA_W-1:0] cfg_data
);
	import lpcmpk_pkg::*;

	localparam int unsigned LEN_MAX = PAYLOAD_LIMIT > MAX_SUB ? PAYLOAD_LIMIT : MAX_SUB;
	localparam int unsigned LEN_W   = $clog2(LEN_MAX + 1);
	localparam int unsigned CNT_W   = $clog2(LEN_MAX + GROUP_MAX + 1);
	localparam int unsigned SUBS_W  = $clog2(PAYLOAD_LIMIT / MIN_SUB + 2);

	cfg_t              cfg;
	logic [LEN_W-1:0]  len;
	logic [SUBS_W-1:0] subs;
	logic              shape_busy, restart;
	logic              q_full, q_not_empty, push, pop;
	job_t              push_job, pop_job;

	lpcmpk_cfg #(
		.PAYLOAD_LIMIT(PAYLOAD_LIMIT),
		.LEN_W(LEN_W),
		.SUBS_W(SUBS_W)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg),
		.len(len),
		.subs(subs),
		.busy(shape_busy),
		.restart(restart)
	);

	lpcmpk_front #(
		.LEN_W(LEN_W),
		.SUBS_W(SUBS_W),
		.CNT_W(CNT_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.cfg(cfg),
		.len(len),
		.subs(subs),
		.shape_busy(shape_busy),
		.restart(restart),
		.q_full(q_full),
		.push(push),
		.push_job(push_job)
	);

	lpcmpk_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.full(q_full),
		.pop(pop),
		.pop_job(pop_job),
		.not_empty(q_not_empty)
	);

	lpcmpk_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg),
		.q_not_empty(q_not_empty),
		.q_job(pop_job),
		.pop(pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

endmodule
`default_nettype wire

// ===== hdl/lpcmpk_checker.sv =====
// Port-level checker for the LPCM packetizer, bound to the top level.
// Depends on lpcmpk_pkg and lpcm_audio_packetizer_unit.
`timescale 1ns / 1ps
`default_nettype none
module lpcmpk_checker (
	input wire                               clk,
	input wire                               arst_n,
	input wire                               s_tready,
	input wire                               m_tvalid,
	input wire                               m_tready,
	input wire [7:0]                         m_tdata,
	input wire [1:0]                         m_tuser,
	input wire                               m_tlast,
	input wire                               cfg_valid,
	input wire                               cfg_ready,
	input wire [lpcmpk_pkg::CFG_IDX_W-1:0]   cfg_index
);
	import lpcmpk_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
		&& $stable(m_tlast))
		else $error("output transaction changed while stalled");

	a_hdr_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
		else $error("header byte flagged as packet end");

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast)
		else $error("packet end not on last byte of a group");

	a_hdr_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tlast)
		else $error("group ends inside header");

	a_cfg_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready && (cfg_index == REG_RATE || cfg_index == REG_CHANS
		|| cfg_index == REG_WIDE) |=> !s_tready)
		else $error("input accepted before packet shape recomputed");

endmodule

bind lpcm_audio_packetizer_unit lpcmpk_checker u_lpcmpk_checker (.*);
`default_nettype wire

// ===== bench/lpcm_audio_packetizer_unit_tb.sv =====
// Self-checking bench for lpcm_audio_packetizer_unit: PCM bytes in, LPCM packet bytes out.
// A scoreboard class predicts headers, byte reordering and packet ends per accepted byte.
// Depends on lpcmpk_pkg and the lpcm_audio_packetizer_unit RTL.
`timescale 1ns / 1ps
module lpcm_audio_packetizer_unit_tb;
	import lpcmpk_pkg::*;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 50000;
	localparam int unsigned SETTLE_CYCLES = 60;
	localparam int unsigned MAX_PRINTS = 40;

	typedef struct {
		logic [7:0] data;
		logic       hdr;
		logic       pend;
		logic       last;
	} pkt_byte_t;

	class packet_scoreboard;
		logic [2:0] rate;
		logic [3:0] chans;
		logic       wide;
		logic [7:0] grp[GROUP_MAX];
		int unsigned fill;
		int unsigned pay_cnt;
		logic [4:0] frame_no;
		logic       hdr_due;
		pkt_byte_t  due_bytes[$];
		int unsigned errors, bytes_in, bytes_out, headers, ends;
		int unsigned wide_pick[GROUP_MAX] = '{2, 1, 5, 4, 8, 7, 6, 11, 0, 3, 10, 9};
		logic [7:0] rate_tag[8] = '{8'h00, 8'h10, 8'h20, 8'h80, 8'h90, 8'hA0, 8'h00, 8'h00};
		int unsigned rate_sub[8] = '{40, 80, 160, 40, 80, 160, 40, 40};

		function new();
			rate = RATE_RST;
			chans = CHANS_RST;
			wide = WIDE_RST;
			restart();
		endfunction

		function void restart();
			foreach (grp[i])
				grp[i] = 8'h00;
			fill = 0;
			pay_cnt = 0;
			frame_no = 5'd0;
			hdr_due = 1'b1;
		endfunction

		function int unsigned channels();
			if (chans == 4'd0)
				return 1;
			if (chans > 4'd8)
				return 8;
			return chans;
		endfunction

		function void shape(output int unsigned len, output int unsigned subs);
			int unsigned sub;
			sub = rate_sub[rate] * channels() * (wide ? 3 : 2);
			subs = PAYLOAD_LIMIT_DEF / sub;
			if (subs == 0)
				subs = 1;
			len = sub * subs;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_RATE: rate = val[2:0];
				REG_CHANS: chans = val;
				REG_WIDE: wide = val[0];
				default: return;
			endcase
			restart();
		endfunction

		function void note_pcm_byte(logic [7:0] b);
			int unsigned gsize, len, subs;
			pkt_byte_t burst[$];
			pkt_byte_t pb;
			logic [7:0] hb[HDR_BYTES];
			gsize = wide ? GROUP_MAX : GROUP_NARROW;
			bytes_in++;
			if (fill >= gsize)
				fill = 0;
			grp[fill] = b;
			fill++;
			if (fill < gsize)
				return;
			fill = 0;
			shape(len, subs);
			if (hdr_due) begin
				frame_no = frame_no + subs[4:0];
				hb = '{HDR_SYNC, {3'd0, frame_no}, 8'h00, HDR_PTR_LO, 8'h00, HDR_PTR_HI, 8'h00,
					wide ? (HDR_LOW | HDR_WIDE) : HDR_LOW, HDR_LOW | rate_tag[rate], 8'h00,
					8'(channels() - 1), HDR_MARK, 8'h00, 8'h00};
				foreach (hb[i])
					burst.push_back('{hb[i], 1'b1, 1'b0, 1'b0});
				hdr_due = 1'b0;
				headers++;
			end
			pay_cnt += gsize;
			for (int unsigned i = 0; i < gsize; i++) begin
				pb.data = wide ? grp[wide_pick[i]] : grp[1 - i];
				pb.hdr = 1'b0;
				pb.pend = (i + 1 == gsize) && (pay_cnt >= len);
				pb.last = (i + 1 == gsize);
				burst.push_back(pb);
			end
			if (pay_cnt >= len) begin
				pay_cnt = 0;
				hdr_due = 1'b1;
				ends++;
			end
			foreach (burst[i])
				due_bytes.push_back(burst[i]);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTS)
				$display("mismatch: %s", msg);
		endtask

		task check_packet_byte(logic [7:0] d, logic hdr, logic pend, logic last);
			pkt_byte_t w;
			bytes_out++;
			if (due_bytes.size() == 0) begin
				report($sformatf("unexpected byte %02h at output byte %0d", d, bytes_out));
				return;
			end
			w = due_bytes.pop_front();
			if (d !== w.data)
				report($sformatf("byte %0d data %02h, want %02h", bytes_out, d, w.data));
			if (hdr !== w.hdr)
				report($sformatf("byte %0d in_header %b, want %b", bytes_out, hdr, w.hdr));
			if (pend !== w.pend)
				report($sformatf("byte %0d packet_end %b, want %b", bytes_out, pend, w.pend));
			if (last !== w.last)
				report($sformatf("byte %0d tlast %b, want %b", bytes_out, last, w.last));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	packet_scoreboard sb = new();
	int unsigned tx_idle = 0;
	int unsigned rx_idle = 0;
	int unsigned hold_req = 0;
	int unsigned hold_left = 0;
	int unsigned cycles = 0;
	int unsigned cfg_writes = 0;

	lpcm_audio_packetizer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("FAIL");
			$finish;
		end
	end

	// receiver: random back-pressure plus long hold-offs on request
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_packet_byte(m_tdata, m_tuser[0], m_tuser[1], m_tlast);
	end

	function automatic logic [7:0] pcm_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_byte(logic [7:0] b);
		while ($urandom_range(99) < tx_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do
			@(posedge clk);
		while (!(s_tvalid && s_tready));
		sb.note_pcm_byte(b);
	endtask

	task automatic wait_drained();
		while (sb.due_bytes.size() != 0)
			@(posedge clk);
	endtask

	task automatic settle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, val);
		cfg_writes++;
	endtask

	task automatic run_phase(logic [2:0] r, logic [3:0] c, logic w, int unsigned n);
		settle();
		write_cfg(REG_RATE, {1'($urandom_range(1)), r});
		write_cfg(REG_CHANS, c);
		write_cfg(REG_WIDE, {3'($urandom_range(7)), w});
		repeat (n) send_byte(pcm_byte());
		s_tvalid <= 1'b0;
	endtask

	initial begin
		int unsigned guard;
		tx_idle = 19;
		rx_idle = 59;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: byte-pair swap, first header
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h55);
		send_byte(8'hAA);
		send_byte(8'h01);
		send_byte(8'h80);
		// partial pair survives a write to an unused index
		send_byte(8'hFE);
		s_tvalid <= 1'b0;
		settle();
		write_cfg(REG_SPARE, 4'hF);
		send_byte(8'h7F);
		// partial pair dropped by a real write; unknown rate acts as 48k
		send_byte(8'h3C);
		s_tvalid <= 1'b0;
		settle();
		write_cfg(REG_RATE, 4'hF);
		send_byte(8'hC3);
		send_byte(8'h96);
		s_tvalid <= 1'b0;
		// 24-bit, zero channels acts as one: walking bits through the group permutation
		settle();
		write_cfg(REG_WIDE, 4'h1);
		write_cfg(REG_CHANS, 4'h0);
		for (int i = 0; i < 12; i++)
			send_byte(i < 8 ? 8'(1 << i) : ~8'(1 << (i - 8)));
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'hA5);
		s_tvalid <= 1'b0;
		// 15 channels acts as 8; subframe beyond the limit gives one per packet
		settle();
		write_cfg(REG_CHANS, 4'hF);
		write_cfg(REG_RATE, 4'h2);
		repeat (12) send_byte(pcm_byte());
		s_tvalid <= 1'b0;

		// sender light, receiver heavy
		run_phase(3'd5, 4'd8, 1'b1, 24);

		// sender heavy, receiver light
		tx_idle = 59;
		rx_idle = 19;
		run_phase(3'd1, 4'd8, 1'b0, 20);
		run_phase(3'($urandom_range(7)), 4'($urandom_range(15)), 1'($urandom_range(1)), 12);

		// no idling; a long receiver hold-off fills the queue and stalls the input
		tx_idle = 0;
		rx_idle = 0;
		run_phase(3'd0, 4'd1, 1'b0, 4);
		hold_req = 60;
		repeat (16) send_byte(pcm_byte());
		s_tvalid <= 1'b0;
		wait_drained();
		run_phase(3'd4, 4'd2, 1'b1, 12);

		guard = 0;
		while (sb.due_bytes.size() != 0 && guard < 50000) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.due_bytes.size() != 0)
			sb.report($sformatf("%0d packet bytes never arrived", sb.due_bytes.size()));
		$display("run: %0d pcm bytes in, %0d packet bytes out, %0d config writes",
			sb.bytes_in, sb.bytes_out, cfg_writes);
		$display("run: %0d headers, %0d packet ends, %0d mismatches",
			sb.headers, sb.ends, sb.errors);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
